// ----- rtl/dgml_pkg.sv -----
// shared types and constants of the minmod edge limiter
package dgml_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned ORDER_W = 2;
  // extended width of edge terms: 30 * 32-bit value plus 6 * 32-bit value
  localparam int unsigned EXT_W   = DATA_W + 7;

  localparam logic [ORDER_W-1:0] ORDER_SLOPE = 2'd2;
  localparam logic [ORDER_W-1:0] ORDER_CURVE = 2'd3;
  localparam logic [ORDER_W-1:0] ORDER_RESET = ORDER_SLOPE;

  localparam logic [1:0] SEEN_NONE     = 2'd0;
  localparam logic [1:0] SEEN_FIRST    = 2'd1;
  localparam logic [1:0] SEEN_INTERIOR = 2'd2;

  localparam int unsigned OUTQ_DEPTH = 4;

  typedef struct packed {
    logic signed [DATA_W-1:0] cur_avg;
    logic signed [DATA_W-1:0] prev_avg;
    logic signed [DATA_W-1:0] older_avg;
    logic signed [DATA_W-1:0] slope;
    logic signed [DATA_W-1:0] curve;
    logic                     emit_held;
    logic                     interior;
    logic                     last;
  } stage_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] left_limited;
    logic signed [DATA_W-1:0] right_limited;
    logic                     final_result;
  } result_t;

  typedef struct packed {
    logic held;
    logic fin;
  } push_t;

endpackage

// ----- rtl/dgml_cell_if.sv -----
// cell stream and result stream channels
interface dgml_cell_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [dgml_pkg::DATA_W-1:0]      cell_average;
  logic signed [dgml_pkg::DATA_W-1:0]      slope_coeff;
  logic signed [dgml_pkg::DATA_W-1:0]      curve_coeff;
  logic                                    last_cell;

  modport source (output valid, cell_average, slope_coeff, curve_coeff, last_cell,
                  input ready);
  modport sink   (input valid, cell_average, slope_coeff, curve_coeff, last_cell,
                  output ready);
endinterface

interface dgml_result_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [dgml_pkg::DATA_W-1:0]      left_limited;
  logic signed [dgml_pkg::DATA_W-1:0]      right_limited;
  logic                                    final_result;

  modport source (output valid, left_limited, right_limited, final_result,
                  input ready);
  modport sink   (input valid, left_limited, right_limited, final_result,
                  output ready);
endinterface

// ----- rtl/dg_minmod_edge_limiter_top.sv -----
// top level of the minmod edge limiter
// a cell's limited result is queued when the stage holding the next cell drains;
//   a last cell's closing zero result is queued in its drain, after any held result
// throughput: one cell per cycle while the result queue has room; a last cell
//   adds one extra result, so the result side, at one transaction per cycle,
//   sets the pace on short domains
// reset (rst, synchronous): window emptied, queue flushed, poly_order back to 2
module dg_minmod_edge_limiter_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [dgml_pkg::ORDER_W-1:0]    cfg_wr_data,
  dgml_cell_if.sink                       cells,
  dgml_result_if.source                   limits
);

  // polynomial order; user writes only while no transaction is in flight, unenforced
  logic [dgml_pkg::ORDER_W-1:0] poly_order;

  // stage register between window and limiter
  dgml_pkg::stage_t  stage;
  logic              stage_valid;
  logic              advance;

  // limiter result and queue push requests
  dgml_pkg::result_t held;
  dgml_pkg::push_t   push;

  // queue can take two more results this cycle
  logic              room;

  always_ff @(posedge clk) begin
    if (rst) begin
      poly_order <= dgml_pkg::ORDER_RESET;
    end else if (cfg_wr_en) begin
      poly_order <= cfg_wr_data;
    end
  end

  // window shift happens at input acceptance; the stage holds the snapshot
  dgml_window u_window (
    .clk         (clk),
    .rst         (rst),
    .cells       (cells),
    .room        (room),
    .stage       (stage),
    .stage_valid (stage_valid),
    .advance     (advance)
  );

  // edge terms and minmod; pushes only when the stage drains
  dgml_limit u_limit (
    .stage      (stage),
    .advance    (advance && stage_valid),
    .poly_order (poly_order),
    .held       (held),
    .push       (push)
  );

  // result queue decouples the two-result burst of a last cell from the sink
  dgml_outq u_outq (
    .clk    (clk),
    .rst    (rst),
    .held   (held),
    .push   (push),
    .room   (room),
    .limits (limits)
  );

endmodule

// ----- rtl/dgml_window.sv -----
// three-cell window and input stage register
module dgml_window (
  input  logic                 clk,
  input  logic                 rst,
  dgml_cell_if.sink            cells,
  input  logic                 room,
  output dgml_pkg::stage_t     stage,
  output logic                 stage_valid,
  output logic                 advance
);

  logic [dgml_pkg::DATA_W-1:0] prev_average;
  logic [dgml_pkg::DATA_W-1:0] older_average;
  logic [dgml_pkg::DATA_W-1:0] prev_slope;
  logic [dgml_pkg::DATA_W-1:0] prev_curve;
  logic [1:0]                  cells_seen;
  logic                        accept;

  assign advance     = stage_valid && room;
  assign cells.ready = !stage_valid || room;
  assign accept      = cells.valid && cells.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage.cur_avg   <= cells.cell_average;
      stage.prev_avg  <= prev_average;
      stage.older_avg <= older_average;
      stage.slope     <= prev_slope;
      stage.curve     <= prev_curve;
      stage.emit_held <= (cells_seen != dgml_pkg::SEEN_NONE);
      stage.interior  <= (cells_seen == dgml_pkg::SEEN_INTERIOR);
      stage.last      <= cells.last_cell;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_average  <= '0;
      older_average <= '0;
      prev_slope    <= '0;
      prev_curve    <= '0;
      cells_seen    <= dgml_pkg::SEEN_NONE;
    end else if (accept) begin
      if (cells.last_cell) begin
        prev_average  <= '0;
        older_average <= '0;
        prev_slope    <= '0;
        prev_curve    <= '0;
        cells_seen    <= dgml_pkg::SEEN_NONE;
      end else begin
        older_average <= prev_average;
        prev_average  <= cells.cell_average;
        prev_slope    <= cells.slope_coeff;
        prev_curve    <= cells.curve_coeff;
        if (cells_seen != dgml_pkg::SEEN_INTERIOR) begin
          cells_seen <= cells_seen + 2'd1;
        end
      end
    end
  end

endmodule

// ----- rtl/dgml_limit.sv -----
// edge terms, minmod and saturation for the held cell
module dgml_limit (
  input  dgml_pkg::stage_t                stage,
  input  logic                            advance,
  input  logic [dgml_pkg::ORDER_W-1:0]    poly_order,
  output dgml_pkg::result_t               held,
  output dgml_pkg::push_t                 push
);

  localparam int unsigned EW = dgml_pkg::EXT_W;
  localparam logic signed [EW-1:0] SAT_HI = EW'(64'sd2147483647);
  localparam logic signed [EW-1:0] SAT_LO = -EW'(64'sd2147483648);

  function automatic logic signed [EW-1:0] minmod(input logic signed [EW-1:0] a,
                                                 input logic signed [EW-1:0] b,
                                                 input logic signed [EW-1:0] c);
    logic                 pos;
    logic                 neg;
    logic signed [EW-1:0] m;
    pos = (a > 0) && (b > 0) && (c > 0);
    neg = (a < 0) && (b < 0) && (c < 0);
    m   = a;
    // same sign: smallest magnitude is the min for positives, max for negatives
    if (pos) begin
      if (b < m) m = b;
      if (c < m) m = c;
    end else if (neg) begin
      if (b > m) m = b;
      if (c > m) m = c;
    end else begin
      m = '0;
    end
    return m;
  endfunction

  function automatic logic signed [dgml_pkg::DATA_W-1:0] sat(
      input logic signed [EW-1:0] v);
    logic signed [EW-1:0] r;
    r = v;
    if (v > SAT_HI) r = SAT_HI;
    if (v < SAT_LO) r = SAT_LO;
    return r[dgml_pkg::DATA_W-1:0];
  endfunction

  logic signed [EW-1:0] slope_x;
  logic signed [EW-1:0] curve_x;
  logic signed [EW-1:0] s6;
  logic signed [EW-1:0] k30;
  logic signed [EW-1:0] edge_l;
  logic signed [EW-1:0] edge_r;
  logic signed [EW-1:0] fwd;
  logic signed [EW-1:0] bwd;

  always_comb begin
    slope_x = EW'(stage.slope);
    curve_x = EW'(stage.curve);
    s6      = (slope_x <<< 2) + (slope_x <<< 1);
    k30     = (poly_order == dgml_pkg::ORDER_CURVE) ?
              ((curve_x <<< 5) - (curve_x <<< 1)) : '0;
    if (poly_order >= dgml_pkg::ORDER_SLOPE) begin
      edge_l = s6 + k30;
      edge_r = s6 - k30;
    end else begin
      edge_l = '0;
      edge_r = '0;
    end
    fwd = EW'(stage.cur_avg) - EW'(stage.prev_avg);
    bwd = EW'(stage.prev_avg) - EW'(stage.older_avg);

    held.final_result = 1'b0;
    if (stage.interior) begin
      held.left_limited  = sat(minmod(edge_l, fwd, bwd));
      held.right_limited = sat(minmod(edge_r, fwd, bwd));
    end else begin
      held.left_limited  = '0;
      held.right_limited = '0;
    end

    push.held = advance && stage.emit_held;
    push.fin  = advance && stage.last;
  end

endmodule

// ----- rtl/dgml_outq.sv -----
// small result queue taking up to two results per cycle
module dgml_outq (
  input  logic                clk,
  input  logic                rst,
  input  dgml_pkg::result_t   held,
  input  dgml_pkg::push_t     push,
  output logic                room,
  dgml_result_if.source       limits
);

  localparam int unsigned DEPTH = dgml_pkg::OUTQ_DEPTH;
  localparam int unsigned PW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  dgml_pkg::result_t entries [DEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic [1:0]        n_push;
  logic              pop;
  dgml_pkg::result_t fin_res;
  dgml_pkg::result_t first_res;

  assign fin_res   = '{left_limited: '0, right_limited: '0, final_result: 1'b1};
  assign first_res = push.held ? held : fin_res;
  assign n_push    = {1'b0, push.held} + {1'b0, push.fin};
  assign pop       = limits.valid && limits.ready;
  assign room      = (count <= CW'(DEPTH - 2));

  assign limits.valid         = (count != '0);
  assign limits.left_limited  = entries[rd_ptr].left_limited;
  assign limits.right_limited = entries[rd_ptr].right_limited;
  assign limits.final_result  = entries[rd_ptr].final_result;

  always_comb begin
    count_next = count + CW'(n_push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(n_push);
      rd_ptr <= rd_ptr + PW'(pop);
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      entries[wr_ptr] <= first_res;
    end
    if (push.held && push.fin) begin
      entries[wr_ptr + PW'(1)] <= fin_res;
    end
  end

endmodule
